// File: sv/brr_block_sample_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// brr decoder assertion macros
// shared check forms, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef BRR_BLOCK_SAMPLE_DECODER_TOP_DEFINES_SVH
`define BRR_BLOCK_SAMPLE_DECODER_TOP_DEFINES_SVH

// condition in a cycle implies a consequence in the same cycle
`define BRR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("brr decoder check failed");

// condition in a cycle implies a consequence in the next cycle
`define BRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brr decoder check failed");

`endif

// File: sv/brr_pkg.sv
// ----------------------------------------------------------------------------
// brr_pkg
// shared types, constants and filter coefficient tables of the brr decoder
// ----------------------------------------------------------------------------
`default_nettype none

package brr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 4;
  localparam int SHIFT_W  = 4;
  localparam int NIB_W    = 4;
  localparam int COEF_W   = 7;
  // product of a coefficient (sign bit added) and a sample
  localparam int PROD_W   = COEF_W + 1 + SAMPLE_W;
  // scaled nibble in 1/64 units: -8 << 21 at most
  localparam int SCALE_W  = 25;
  localparam int FRAC_W   = 6;
  localparam int ACC_W    = 27;
  localparam int QUOT_W   = ACC_W - FRAC_W;

  // block positions
  localparam logic [POS_W-1:0] POS_HEADER    = 4'd0;
  localparam logic [POS_W-1:0] POS_FIRST     = 4'd1;
  localparam logic [POS_W-1:0] POS_LAST_DATA = 4'd8;

  // prediction filters
  typedef enum logic [1:0] {
    FILTER_NONE  = 2'd0,
    FILTER_ONE   = 2'd1,
    FILTER_TWO   = 2'd2,
    FILTER_THREE = 2'd3
  } filter_t;

  // one decoded result
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_byte;
    logic                       end_of_block;
  } result_t;

  // core status seen by the top level
  typedef struct packed {
    logic busy;
    logic second_half;
  } core_status_t;

  // weight of the last sample in 1/64 units
  function automatic logic [COEF_W-1:0] coef_last(input filter_t f);
    logic [COEF_W-1:0] c;
    unique case (f)
      FILTER_NONE:  c = 7'd0;
      FILTER_ONE:   c = 7'd60;
      FILTER_TWO:   c = 7'd122;
      FILTER_THREE: c = 7'd115;
      default:      c = 7'd0;
    endcase
    return c;
  endfunction

  // weight of the older sample in 1/64 units, subtracted
  function automatic logic [COEF_W-1:0] coef_older(input filter_t f);
    logic [COEF_W-1:0] c;
    unique case (f)
      FILTER_NONE:  c = 7'd0;
      FILTER_ONE:   c = 7'd0;
      FILTER_TWO:   c = 7'd60;
      FILTER_THREE: c = 7'd52;
      default:      c = 7'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/brr_block_sample_decoder_top.sv
// ----------------------------------------------------------------------------
// brr_block_sample_decoder_top
// byte-serial decoder of 9-byte bit-rate-reduced adpcm blocks
// ----------------------------------------------------------------------------
// Takes one byte per transfer: a header (shift in bits 7-4, filter in bits
// 3-2) and then eight data bytes, each giving two signed 16-bit samples, high
// nibble first. A header passes through the input stage and yields nothing;
// a data byte stays there for both samples, which go one after the other
// through the single predictor whose history feeds back after each sample.
// The rate is one sample per cycle during data bytes while the output is
// not stalled. A sample enters the output register when it is taken, and
// the next byte is taken while a result waits. new_stream with a byte
// clears the history and starts a new block at that byte.
`default_nettype none
`include "brr_block_sample_decoder_top_defines.svh"

module brr_block_sample_decoder_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [7:0]                          data_byte,
  input  wire logic                                new_stream,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [brr_pkg::SAMPLE_W-1:0]      sample,
  output logic                                     last_of_byte,
  output logic                                     end_of_block
);

  logic                  res_valid;
  brr_pkg::result_t      res;
  brr_pkg::core_status_t status;
  logic                  out_space;

  // output register frees when empty or taken
  assign out_space = !out_valid || out_ready;

  brr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .new_stream (new_stream),
    .res_take   (out_space),
    .res_valid  (res_valid),
    .res        (res),
    .status     (status)
  );

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && out_space) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (res_valid && out_space) begin
      sample       <= res.sample;
      last_of_byte <= res.last_of_byte;
      end_of_block <= res.end_of_block;
    end
  end

  // checks
  `BRR_ASSERT_NOW(a_idle_ready, !status.busy, in_ready)
  `BRR_ASSERT_NOW(a_half_busy, status.second_half, status.busy)
  `BRR_ASSERT_NOW(a_end_is_last, out_valid && end_of_block, last_of_byte)
  `BRR_ASSERT_NEXT(a_half_clears, res_valid && out_space && status.second_half, !status.second_half)

endmodule

`default_nettype wire

// File: sv/brr_calc.sv
// ----------------------------------------------------------------------------
// brr_calc
// one sample: scaled nibble plus filter prediction, truncated and saturated
// ----------------------------------------------------------------------------
`default_nettype none

module brr_calc (
  input  wire logic [brr_pkg::NIB_W-1:0]           nibble,
  input  wire logic [brr_pkg::SHIFT_W-1:0]         shift_amount,
  input  wire brr_pkg::filter_t                     filter_select,
  input  wire logic signed [brr_pkg::SAMPLE_W-1:0] last_sample,
  input  wire logic signed [brr_pkg::SAMPLE_W-1:0] older_sample,
  output logic signed [brr_pkg::SAMPLE_W-1:0]      sample
);

  logic signed [brr_pkg::NIB_W-1:0]    nib_s;
  logic signed [brr_pkg::SCALE_W-1:0]  scaled;
  logic signed [brr_pkg::COEF_W:0]     ca;
  logic signed [brr_pkg::COEF_W:0]     cb;
  logic signed [brr_pkg::PROD_W-1:0]   pa;
  logic signed [brr_pkg::PROD_W-1:0]   pb;
  logic signed [brr_pkg::ACC_W-1:0]    acc;
  logic signed [brr_pkg::ACC_W-1:0]    bias;
  logic signed [brr_pkg::ACC_W-1:0]    shifted;
  logic signed [brr_pkg::QUOT_W-1:0]   quot;
  logic [brr_pkg::SHIFT_W:0]           total_shift;

  // nibble scaled into 1/64 units
  assign nib_s       = $signed(nibble);
  assign total_shift = {1'b0, shift_amount} + 5'(brr_pkg::FRAC_W);
  assign scaled      = brr_pkg::SCALE_W'(nib_s) <<< total_shift;

  // prediction products
  assign ca = $signed({1'b0, brr_pkg::coef_last(filter_select)});
  assign cb = $signed({1'b0, brr_pkg::coef_older(filter_select)});
  assign pa = ca * last_sample;
  assign pb = cb * older_sample;

  // exact sum, then truncate toward zero
  assign acc     = brr_pkg::ACC_W'(scaled) + brr_pkg::ACC_W'(pa) - brr_pkg::ACC_W'(pb);
  assign bias    = acc[brr_pkg::ACC_W-1] ? brr_pkg::ACC_W'(63) : '0;
  assign shifted = (acc + bias) >>> brr_pkg::FRAC_W;
  assign quot    = shifted[brr_pkg::QUOT_W-1:0];

  // saturate to signed 16 bits
  always_comb begin
    if (quot > brr_pkg::QUOT_W'(32767)) begin
      sample = 16'sh7fff;
    end else if (quot < -brr_pkg::QUOT_W'(32768)) begin
      sample = 16'sh8000;
    end else begin
      sample = quot[brr_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: sv/brr_core.sv
// ----------------------------------------------------------------------------
// brr_core
// input byte register, block position, header fields and sample history
// ----------------------------------------------------------------------------
`default_nettype none

module brr_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   data_byte,
  input  wire logic                         new_stream,
  input  wire logic                         res_take,
  output logic                              res_valid,
  output brr_pkg::result_t                  res,
  output brr_pkg::core_status_t             status
);

  logic                                stage_valid;
  logic [7:0]                          stage_byte;
  logic                                stage_fresh;
  logic                                phase;
  logic [brr_pkg::POS_W-1:0]           byte_position;
  logic [brr_pkg::SHIFT_W-1:0]         shift_amount;
  brr_pkg::filter_t                    filter_select;
  logic signed [brr_pkg::SAMPLE_W-1:0] last_sample;
  logic signed [brr_pkg::SAMPLE_W-1:0] older_sample;

  logic [brr_pkg::POS_W-1:0]           pos_eff;
  logic                                is_header;
  logic                                in_xfer;
  logic                                res_xfer;
  logic                                stage_done;
  logic [brr_pkg::NIB_W-1:0]           nibble;
  logic signed [brr_pkg::SAMPLE_W-1:0] new_sample;

  // a fresh stream always starts at a header
  assign pos_eff   = stage_fresh ? brr_pkg::POS_HEADER : byte_position;
  assign is_header = (pos_eff == brr_pkg::POS_HEADER) || (pos_eff > brr_pkg::POS_LAST_DATA);

  // handshake and stage progress
  assign res_valid  = stage_valid && !is_header;
  assign res_xfer   = res_valid && res_take;
  assign stage_done = stage_valid && (is_header || (res_xfer && phase));
  assign in_ready   = !stage_valid || stage_done;
  assign in_xfer    = in_valid && in_ready;

  // high nibble first
  assign nibble = phase ? stage_byte[3:0] : stage_byte[7:4];

  brr_calc u_calc (
    .nibble        (nibble),
    .shift_amount  (shift_amount),
    .filter_select (filter_select),
    .last_sample   (last_sample),
    .older_sample  (older_sample),
    .sample        (new_sample)
  );

  // result toward the output register
  assign res.sample       = new_sample;
  assign res.last_of_byte = phase;
  assign res.end_of_block = phase && (byte_position == brr_pkg::POS_LAST_DATA);

  assign status.busy        = stage_valid;
  assign status.second_half = phase;

  // input stage payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stage_byte <= data_byte;
    end
  end

  // stage control, block state and history
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid   <= 1'b0;
      stage_fresh   <= 1'b0;
      phase         <= 1'b0;
      byte_position <= brr_pkg::POS_HEADER;
      shift_amount  <= '0;
      filter_select <= brr_pkg::FILTER_NONE;
      last_sample   <= '0;
      older_sample  <= '0;
    end else begin
      if (in_xfer) begin
        stage_valid <= 1'b1;
        stage_fresh <= new_stream;
      end else if (stage_done) begin
        stage_valid <= 1'b0;
      end

      if (stage_valid && is_header) begin
        shift_amount  <= stage_byte[7:4];
        filter_select <= brr_pkg::filter_t'(stage_byte[3:2]);
        byte_position <= brr_pkg::POS_FIRST;
        if (stage_fresh) begin
          last_sample  <= '0;
          older_sample <= '0;
        end
      end else if (res_xfer) begin
        older_sample <= last_sample;
        last_sample  <= new_sample;
        phase        <= !phase;
        if (phase) begin
          byte_position <= (byte_position == brr_pkg::POS_LAST_DATA) ?
                           brr_pkg::POS_HEADER : byte_position + 4'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sim/tb_brr_block_sample_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_brr_block_sample_decoder_top
// self-checking bench for the byte-serial brr block decoder
// ----------------------------------------------------------------------------
// A short opening stream covers the nibble extremes, every filter, large
// shifts that saturate, a complete block and new_stream both mid-block and on
// a header. Random blocks follow, mostly well formed with some noise and
// broken blocks. Input transfers are noted in a tracker that predicts the
// decoded samples, and each output transfer is compared with the oldest
// prediction. The sender works in bursts. The receiver stalls on its own
// pattern and once holds off long enough to back up the input.
`default_nettype none

// predicts decoded samples from accepted bytes and checks the output against them
class brr_sample_tracker;
  brr_pkg::result_t                      pending_q[$];
  logic [brr_pkg::POS_W-1:0]             position;
  logic [brr_pkg::SHIFT_W-1:0]           shift_amt;
  brr_pkg::filter_t                      filter_sel;
  logic signed [brr_pkg::SAMPLE_W-1:0]   prev_sample;
  logic signed [brr_pkg::SAMPLE_W-1:0]   prev2_sample;
  int unsigned                           mismatches;

  function new();
    position     = brr_pkg::POS_HEADER;
    shift_amt    = '0;
    filter_sel   = brr_pkg::FILTER_NONE;
    prev_sample  = '0;
    prev2_sample = '0;
    mismatches   = 0;
  endfunction

  // one sample: scaled nibble plus weighted history in 1/64 units
  function logic signed [brr_pkg::SAMPLE_W-1:0] predict(logic [3:0] nib);
    longint weight_a;
    longint weight_b;
    longint acc;
    longint q;
    case (filter_sel)
      brr_pkg::FILTER_ONE: begin
        weight_a = 60;
        weight_b = 0;
      end
      brr_pkg::FILTER_TWO: begin
        weight_a = 122;
        weight_b = 60;
      end
      brr_pkg::FILTER_THREE: begin
        weight_a = 115;
        weight_b = 52;
      end
      default: begin
        weight_a = 0;
        weight_b = 0;
      end
    endcase
    acc = longint'($signed(nib)) * (longint'(1) << shift_amt) * 64
        + weight_a * longint'(prev_sample) - weight_b * longint'(prev2_sample);
    // signed division truncates toward zero
    q = acc / 64;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    prev2_sample = prev_sample;
    prev_sample  = 16'(q);
    return prev_sample;
  endfunction

  // accepted input transfer
  function void take_byte(logic [7:0] b, logic fresh);
    brr_pkg::result_t r;
    if (fresh) begin
      position     = brr_pkg::POS_HEADER;
      prev_sample  = '0;
      prev2_sample = '0;
    end
    // header: shift and filter only, bits 1-0 ignored
    if (position == brr_pkg::POS_HEADER || position > brr_pkg::POS_LAST_DATA) begin
      shift_amt  = b[7:4];
      filter_sel = brr_pkg::filter_t'(b[3:2]);
      position   = brr_pkg::POS_FIRST;
      return;
    end
    // data byte: high nibble first
    r.sample       = predict(b[7:4]);
    r.last_of_byte = 1'b0;
    r.end_of_block = 1'b0;
    pending_q.push_back(r);
    r.sample       = predict(b[3:0]);
    r.last_of_byte = 1'b1;
    r.end_of_block = (position == brr_pkg::POS_LAST_DATA);
    pending_q.push_back(r);
    position = (position == brr_pkg::POS_LAST_DATA) ? brr_pkg::POS_HEADER
                                                      : position + 4'd1;
  endfunction

  // accepted output transfer
  function void compare_sample(logic signed [brr_pkg::SAMPLE_W-1:0] s, logic lob,
                               logic eob);
    brr_pkg::result_t exp_r;
    if (pending_q.size() == 0) begin
      $error("sample %0d arrived with no prediction waiting", s);
      mismatches++;
      return;
    end
    exp_r = pending_q.pop_front();
    if (s !== exp_r.sample) begin
      $error("sample: expected %0d, actual %0d", exp_r.sample, s);
      mismatches++;
    end
    if (lob !== exp_r.last_of_byte) begin
      $error("last_of_byte: expected %0b, actual %0b", exp_r.last_of_byte, lob);
      mismatches++;
    end
    if (eob !== exp_r.end_of_block) begin
      $error("end_of_block: expected %0b, actual %0b", exp_r.end_of_block, eob);
      mismatches++;
    end
  endfunction

  function int pending_count();
    return pending_q.size();
  endfunction
endclass

module tb_brr_block_sample_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 450;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 300;

  logic                                 clk;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic [7:0]                           data_byte = 8'h00;
  logic                                 new_stream = 1'b0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic signed [brr_pkg::SAMPLE_W-1:0]  sample;
  logic                                 last_of_byte;
  logic                                 end_of_block;

  brr_sample_tracker tracker = new();
  int unsigned bytes_taken = 0;
  int unsigned burst_left  = 0;

  brr_block_sample_decoder_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .new_stream   (new_stream),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample       (sample),
    .last_of_byte (last_of_byte),
    .end_of_block (end_of_block)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // output transfers
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.compare_sample(sample, last_of_byte, end_of_block);
  end

  // receiver: phases of varying stall rate, one long hold-off
  initial begin
    int unsigned phase_len;
    int unsigned stall_pct;
    bit          held;
    held = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && bytes_taken >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end else begin
        phase_len = $urandom_range(10, 80);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
        repeat (phase_len) begin
          out_ready <= ($urandom_range(0, 99) >= stall_pct);
          @(negedge clk);
        end
      end
    end
  end

  // one input transfer, held until accepted
  task automatic send_byte(input logic [7:0] b, input logic fresh);
    @(negedge clk);
    in_valid   <= 1'b1;
    data_byte  <= b;
    new_stream <= fresh;
    do @(posedge clk); while (!in_ready);
    tracker.take_byte(b, fresh);
    bytes_taken++;
  endtask

  // sender bursts with random gaps between them
  task automatic next_byte(input logic [7:0] b, input logic fresh);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    send_byte(b, fresh);
  endtask

  // stimulus and end of run
  initial begin
    int unsigned start_count;
    int unsigned run_len;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // saturation at the widest shift, filter 0, low header bits set
    next_byte(8'hF3, 1'b1);
    next_byte(8'h78, 1'b0);
    next_byte(8'h87, 1'b0);
    // new stream mid-block: filter 3 runs into both rails
    next_byte(8'hCE, 1'b1);
    next_byte(8'h77, 1'b0);
    next_byte(8'h77, 1'b0);
    next_byte(8'h88, 1'b0);
    // full block with filter 2 and a large shift
    next_byte(8'hD9, 1'b1);
    next_byte(8'h77, 1'b0);
    next_byte(8'h70, 1'b0);
    next_byte(8'h08, 1'b0);
    next_byte(8'h80, 1'b0);
    next_byte(8'hF1, 1'b0);
    next_byte(8'h00, 1'b0);
    next_byte(8'h88, 1'b0);
    next_byte(8'h7F, 1'b0);
    // header right after the block end, filter 1
    next_byte(8'h05, 1'b0);
    next_byte(8'hFF, 1'b0);
    next_byte(8'h00, 1'b0);
    // new stream where a data byte would go
    next_byte(8'h17, 1'b1);
    next_byte(8'h80, 1'b0);

    // random blocks, some broken, some noise
    start_count = bytes_taken;
    while (bytes_taken - start_count < RANDOM_BYTES) begin
      if ($urandom_range(0, 99) < 80) begin
        next_byte(8'($urandom), ($urandom_range(0, 4) == 0));
        for (int i = 0; i < 8; i++)
          next_byte(8'($urandom), ($urandom_range(0, 63) == 0));
      end else begin
        run_len = $urandom_range(1, 5);
        repeat (run_len) next_byte(8'($urandom), ($urandom_range(0, 3) == 0));
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then a further wait for anything stray
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("PASS brr_block_sample_decoder_top");
    end else begin
      $display("FAIL brr_block_sample_decoder_top");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL brr_block_sample_decoder_top");
    $finish;
  end
endmodule

`default_nettype wire

// File: filelist.f
+incdir+sv
sv/brr_pkg.sv
sv/brr_calc.sv
sv/brr_core.sv
sv/brr_block_sample_decoder_top.sv
sim/tb_brr_block_sample_decoder_top.sv
